### rtl/hht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hht_pkg
// Shared widths, command codes and parameter defaults for the hopscotch hash
// table engine.
// ----------------------------------------------------------------------------
package hht_pkg;

    localparam int KEY_W      = 31;
    localparam int SLOTS_DEF  = 16;
    localparam int HOOD_DEF   = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

endpackage

### rtl/hht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hopscotch_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopscotch_hash_table
// Hopscotch hash table engine: insert or search one key per input word.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot flags and bitmaps, one slot a cycle,
// before it takes the first word. Each word then works alone: the quotient
// of the key by SLOTS comes from a reciprocal multiply as the word is taken,
// and the next state, S_MOD, yields the home slot. A search then reads the
// home bitmap (S_SBM, S_SBW), reads and compares each named slot (S_SRD,
// S_SCMP), passes each clear bit in S_SRD alone, and posts the result from
// S_DONE. An insert probes one slot a cycle through the flag RAM, then runs
// displacement rounds (check, bitmap read per candidate, key move, flag
// release), then a final check, a store through S_INSRD and S_INSWR, and
// the post from S_DONE. The input is not ready until the result is posted;
// a result that is not taken holds the next one in S_DONE. Every step
// reuses the single read and write port of each RAM.
// ----------------------------------------------------------------------------
module hopscotch_hash_table
    import hht_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int NEIGHBORHOOD = HOOD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_ok
);

    localparam int AW = $clog2(SLOTS);
    localparam int HW = $clog2(NEIGHBORHOOD);
    localparam int XW = ((AW > HW) ? AW : HW) + 1;
    localparam int N  = NEIGHBORHOOD;
    localparam int SH = KEY_W + AW;
    localparam int PW = KEY_W + 32;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_PROBE  = 4'd3;
    localparam logic [3:0] S_DCHK   = 4'd4;
    localparam logic [3:0] S_DCAND  = 4'd5;
    localparam logic [3:0] S_DBITS  = 4'd6;
    localparam logic [3:0] S_DMOVE  = 4'd7;
    localparam logic [3:0] S_DFREE  = 4'd8;
    localparam logic [3:0] S_INSRD  = 4'd9;
    localparam logic [3:0] S_INSWR  = 4'd10;
    localparam logic [3:0] S_SBM    = 4'd11;
    localparam logic [3:0] S_SBW    = 4'd12;
    localparam logic [3:0] S_SRD    = 4'd13;
    localparam logic [3:0] S_SCMP   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [31:0]      RECIP      = 32'(RECIP_L);
    localparam logic [N-1:0]     ONE_N      = {{(N-1){1'b0}}, 1'b1};
    localparam logic [XW-1:0]    SLOTS_X    = XW'(SLOTS);
    localparam logic [XW-1:0]    HOOD_X     = XW'(N);
    localparam logic [HW-1:0]    K_LAST     = HW'(N-1);
    localparam logic [AW:0]      SLOTS_P    = (AW+1)'(SLOTS);

    logic [3:0]    r_state, n_state;
    logic          r_cmd, n_cmd;
    t_key          r_key, n_key;
    logic [AW-1:0] r_quo, n_quo;
    logic [AW-1:0] r_home, n_home;
    logic [AW-1:0] r_free, n_free;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_own, n_own;
    logic [AW:0]   r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [HW-1:0] r_k, n_k;
    logic [N-1:0]  r_bm, n_bm;
    logic          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    logic          r_out_ok, n_out_ok;

    logic          key_we, used_we, used_wdata, bm_we;
    logic [AW-1:0] key_waddr, key_raddr, used_waddr, used_raddr, bm_waddr, bm_raddr;
    t_key          key_wdata, key_q;
    logic          used_q;
    logic [N-1:0]  bm_wdata, bm_q;

    logic [PW-1:0] w_prod;
    logic [AW-1:0] w_quo, w_quo_mul;
    logic [AW:0]   w_ptr_m1;
    logic [XW-1:0] w_diff, w_own, w_own_first, w_own_next, w_pos, w_src;
    logic          w_hit;
    logic [HW-1:0] w_d;

    hht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_q)
    );

    hht_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (used_raddr),
        .o_rdata (used_q)
    );

    hht_ram #(.WIDTH(N), .DEPTH(SLOTS)) u_bm_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_q)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_ok    = r_out_ok;

    always_comb begin
        w_prod      = PW'(i_key) * PW'(RECIP);
        w_quo       = w_prod[SH+AW-1:SH];
        w_quo_mul   = AW'(32'(r_quo) * 32'(SLOTS));
        w_ptr_m1    = r_ptr - 1'b1;
        w_diff      = XW'(r_free) - XW'(r_home);
        w_own       = XW'(r_free) - XW'(r_k);
        w_own_first = XW'(r_free) - XW'(N-1);
        w_own_next  = w_own + 1'b1;
        w_pos       = XW'(r_home) + XW'(r_k);
        w_hit       = 1'b0;
        w_d         = '0;
        for (int d = 1; d < N; d++) begin
            if (bm_q[d] && (HW'(d) < r_k)) begin
                w_hit = 1'b1;
                w_d   = HW'(d);
            end
        end
        w_src       = w_own + XW'(w_d);
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_quo       = r_quo;
        n_home      = r_home;
        n_free      = r_free;
        n_src       = r_src;
        n_own       = r_own;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_k         = r_k;
        n_bm        = r_bm;
        n_res       = r_res;
        n_out_valid = r_out_valid & ~i_ready;
        n_out_ok    = r_out_ok;

        key_we      = 1'b0;
        key_waddr   = r_free;
        key_wdata   = key_q;
        key_raddr   = '0;
        used_we     = 1'b0;
        used_waddr  = r_free;
        used_wdata  = 1'b1;
        used_raddr  = '0;
        bm_we       = 1'b0;
        bm_waddr    = r_own;
        bm_wdata    = r_bm;
        bm_raddr    = '0;

        unique case (r_state)
            S_CLR: begin
                used_we    = 1'b1;
                used_waddr = r_ptr[AW-1:0];
                used_wdata = 1'b0;
                bm_we      = 1'b1;
                bm_waddr   = r_ptr[AW-1:0];
                bm_wdata   = '0;
                n_ptr      = r_ptr + 1'b1;
                if (r_ptr == SLOTS_P - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_key   = i_key;
                    n_quo   = w_quo;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_home  = r_key[AW-1:0] - w_quo_mul;
                n_ptr   = {1'b0, n_home};
                n_pend  = 1'b0;
                n_state = (r_cmd == CMD_INSERT) ? S_PROBE : S_SBM;
            end
            S_PROBE: begin
                used_raddr = r_ptr[AW-1:0];
                if (r_pend && !used_q) begin
                    n_free  = w_ptr_m1[AW-1:0];
                    n_state = S_DCHK;
                end else if (r_ptr == SLOTS_P) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_DCHK: begin
                n_state = (w_diff >= HOOD_X) ? S_DCAND : S_INSRD;
            end
            S_DCAND: begin
                bm_raddr = w_own_first[AW-1:0];
                n_k      = K_LAST;
                n_state  = S_DBITS;
            end
            S_DBITS: begin
                if (w_hit) begin
                    n_own     = w_own[AW-1:0];
                    n_src     = w_src[AW-1:0];
                    n_bm      = (bm_q & ~(ONE_N << w_d)) | (ONE_N << r_k);
                    key_raddr = w_src[AW-1:0];
                    n_state   = S_DMOVE;
                end else if (r_k == HW'(1)) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    bm_raddr = w_own_next[AW-1:0];
                    n_k      = r_k - 1'b1;
                end
            end
            S_DMOVE: begin
                key_we    = 1'b1;
                key_waddr = r_free;
                key_wdata = key_q;
                used_we   = 1'b1;
                bm_we     = 1'b1;
                n_state   = S_DFREE;
            end
            S_DFREE: begin
                used_we    = 1'b1;
                used_waddr = r_src;
                used_wdata = 1'b0;
                n_free     = r_src;
                n_state    = S_DCHK;
            end
            S_INSRD: begin
                bm_raddr = r_home;
                n_state  = S_INSWR;
            end
            S_INSWR: begin
                key_we    = 1'b1;
                key_wdata = r_key;
                used_we   = 1'b1;
                bm_we     = 1'b1;
                bm_waddr  = r_home;
                bm_wdata  = bm_q | (ONE_N << w_diff[HW-1:0]);
                n_res     = 1'b1;
                n_state   = S_DONE;
            end
            S_SBM: begin
                bm_raddr = r_home;
                n_state  = S_SBW;
            end
            S_SBW: begin
                n_bm    = bm_q;
                n_k     = '0;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (r_bm[r_k] && (w_pos < SLOTS_X)) begin
                    used_raddr = w_pos[AW-1:0];
                    key_raddr  = w_pos[AW-1:0];
                    n_state    = S_SCMP;
                end else if (r_k == K_LAST) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SCMP: begin
                if (used_q && (key_q == r_key)) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else if (r_k == K_LAST) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_quo    <= n_quo;
        r_home   <= n_home;
        r_free   <= n_free;
        r_src    <= n_src;
        r_own    <= n_own;
        r_k      <= n_k;
        r_bm     <= n_bm;
        r_res    <= n_res;
        r_out_ok <= n_out_ok;
    end

endmodule
